// ===== sv/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// ple_pkg
// shared widths, command codes and the result record of the list engine
// ---------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEFAULT = 32;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SORT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        entry_count;
        logic                      last;
    } ple_result_t;

endpackage

// ===== sv/ple_req_if.sv =====
// ---------------------------------------------------------------------------
// ple_req_if
// request channel: one command with its position and value
// ---------------------------------------------------------------------------
interface ple_req_if;
    import ple_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, output command, output position, output item_value,
                    input ready);
    modport sink   (input valid, input command, input position, input item_value,
                    output ready);
endinterface

// ===== sv/ple_rsp_if.sv =====
// ---------------------------------------------------------------------------
// ple_rsp_if
// result channel: status, value, count and end-of-command flag
// ---------------------------------------------------------------------------
interface ple_rsp_if;
    import ple_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic signed [VALUE_W-1:0] result_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      last;

    modport source (output valid, output ok, output result_value, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input ok, input result_value, input entry_count,
                    input last, output ready);
endinterface

// ===== sv/ple_store.sv =====
// ---------------------------------------------------------------------------
// ple_store
// value memory, one write port and one registered read port
// ---------------------------------------------------------------------------
module ple_store #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [ple_pkg::VALUE_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr,
    output logic signed [ple_pkg::VALUE_W-1:0] rd_data
);
    import ple_pkg::*;

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== sv/ple_ctrl.sv =====
// ---------------------------------------------------------------------------
// ple_ctrl
// command sequencer: walks the value memory for insert, delete, sort, dump
// ---------------------------------------------------------------------------
module ple_ctrl #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ple_req_if.sink                            req,
    input  logic                               out_free,
    output logic                               out_load,
    output ple_pkg::ple_result_t               out_result,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic signed [ple_pkg::VALUE_W-1:0] wr_data,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  logic signed [ple_pkg::VALUE_W-1:0] rd_data
);
    import ple_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INS_RD   = 4'd1;
    localparam logic [3:0] ST_INS_WR   = 4'd2;
    localparam logic [3:0] ST_DEL_RD0  = 4'd3;
    localparam logic [3:0] ST_DEL_GET  = 4'd4;
    localparam logic [3:0] ST_DEL_RD   = 4'd5;
    localparam logic [3:0] ST_DEL_WR   = 4'd6;
    localparam logic [3:0] ST_SRT_I    = 4'd7;
    localparam logic [3:0] ST_SRT_HOLD = 4'd8;
    localparam logic [3:0] ST_SRT_J    = 4'd9;
    localparam logic [3:0] ST_SRT_CMP  = 4'd10;
    localparam logic [3:0] ST_SRT_WI   = 4'd11;
    localparam logic [3:0] ST_DMP_RD   = 4'd12;
    localparam logic [3:0] ST_DMP_OUT  = 4'd13;
    localparam logic [3:0] ST_EMIT     = 4'd14;

    logic [3:0]                state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             jdx_reg, jdx_next;
    logic [AW-1:0]             pos_reg, pos_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] hold_reg, hold_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    logic                      ok_reg, ok_next;

    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;
    logic          pos_zero;
    logic          ins_good;
    logic          del_good;
    logic          idx_more;
    logic          jdx_more;
    logic          dmp_last;

    assign pos_w    = PW'(req.position);
    assign cnt_w    = PW'(cnt_reg);
    assign pos_zero = (req.position == '0);
    assign ins_good = !pos_zero && (pos_w <= cnt_w + PW'(1)) && (cnt_w < PW'(CAPACITY));
    assign del_good = !pos_zero && (pos_w <= cnt_w);
    assign idx_more = (CW'(idx_reg) + CW'(1)) < cnt_reg;
    assign jdx_more = (CW'(jdx_reg) + CW'(1)) < cnt_reg;
    assign dmp_last = !idx_more;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        jdx_next   = jdx_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        hold_next  = hold_reg;
        res_next   = res_reg;
        ok_next    = ok_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        out_load   = 1'b0;
        out_result.ok          = ok_reg;
        out_result.value       = res_reg;
        out_result.entry_count = COUNT_W'(cnt_reg);
        out_result.last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    pos_next = AW'(req.position - POS_W'(1));
                    val_next = req.item_value;
                    ok_next  = 1'b0;
                    res_next = '0;
                    case (req.command)
                        CMD_INSERT:
                        begin
                            if (ins_good)
                            begin
                                idx_next   = AW'(cnt_reg);
                                state_next = ST_INS_RD;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (del_good)
                            begin
                                idx_next   = AW'(req.position - POS_W'(1));
                                state_next = ST_DEL_RD0;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_SORT:
                        begin
                            idx_next   = '0;
                            state_next = ST_SRT_I;
                        end
                        CMD_DUMP:
                        begin
                            idx_next   = '0;
                            state_next = (cnt_reg == '0) ? ST_EMIT : ST_DMP_RD;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            // shift entries up from the tail, then drop the new value in
            ST_INS_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg - AW'(1);
                    state_next = ST_INS_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    ok_next    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                idx_next   = idx_reg - AW'(1);
                state_next = ST_INS_RD;
            end

            // capture the victim, then close the gap
            ST_DEL_RD0:
            begin
                rd_en      = 1'b1;
                state_next = ST_DEL_GET;
            end
            ST_DEL_GET:
            begin
                res_next   = rd_data;
                state_next = ST_DEL_RD;
            end
            ST_DEL_RD:
            begin
                if (idx_more)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + AW'(1);
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    ok_next    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_DEL_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg + AW'(1);
                state_next = ST_DEL_RD;
            end

            // exchange sort: slot i lives in hold_reg during its pass
            ST_SRT_I:
            begin
                if (idx_more)
                begin
                    rd_en      = 1'b1;
                    jdx_next   = idx_reg + AW'(1);
                    state_next = ST_SRT_HOLD;
                end
                else
                begin
                    ok_next    = 1'b1;
                    res_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_SRT_HOLD:
            begin
                hold_next  = rd_data;
                state_next = ST_SRT_J;
            end
            ST_SRT_J:
            begin
                rd_en      = 1'b1;
                rd_addr    = jdx_reg;
                state_next = ST_SRT_CMP;
            end
            ST_SRT_CMP:
            begin
                if (hold_reg > rd_data)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = jdx_reg;
                    wr_data   = hold_reg;
                    hold_next = rd_data;
                end
                if (jdx_more)
                begin
                    jdx_next   = jdx_reg + AW'(1);
                    state_next = ST_SRT_J;
                end
                else
                begin
                    state_next = ST_SRT_WI;
                end
            end
            ST_SRT_WI:
            begin
                wr_en      = 1'b1;
                wr_data    = hold_reg;
                idx_next   = idx_reg + AW'(1);
                state_next = ST_SRT_I;
            end

            // one read per dumped value, held until the output slot frees
            ST_DMP_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_DMP_OUT;
            end
            ST_DMP_OUT:
            begin
                out_result.ok    = 1'b1;
                out_result.value = rd_data;
                out_result.last  = dmp_last;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (dmp_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_DMP_RD;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        jdx_reg  <= jdx_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        hold_reg <= hold_next;
        res_reg  <= res_next;
        ok_reg   <= ok_next;
    end
endmodule

// ===== sv/positional_list_engine.sv =====
// walk: insert and delete move each shifted entry with a read and a write, sort makes one outer
//   pass per slot but the last, with a compare per later slot, dump reads and emits each value in turn
// throughput: one request at a time; the walk over the value memory sets how long each one takes
// reset: rst_n clears the entry count and the output slot; memory contents are not cleared,
//   and only entries below the count are ever read
// ---------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed values with insert, delete, sort and dump requests
// ---------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    // memory port between sequencer and store
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;

    // output slot: the sequencer keeps working while a result waits here
    logic        out_valid_reg, out_valid_next;
    ple_result_t out_data_reg;
    logic        out_free;
    logic        out_load;
    ple_result_t out_result;

    ple_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_result (out_result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_result;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_data_reg.ok;
    assign rsp.result_value = out_data_reg.value;
    assign rsp.entry_count  = out_data_reg.entry_count;
    assign rsp.last         = out_data_reg.last;
endmodule
